// ===== src/wpfb_pkg.sv =====
// Shared constants and types for the windowed page frame buffer write block.
// Used by the top level and the testbench.
// No dependencies.
package wpfb_pkg;

	// Screen geometry: pages of eight pixel rows by columns.
	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int PAGE_COUNT    = SCREEN_HEIGHT / 8;
	localparam int STORE_DEPTH   = PAGE_COUNT * SCREEN_WIDTH;
	localparam int ADDR_W        = $clog2(STORE_DEPTH);

	// Row arithmetic: window_top (7 bits) plus a row offset of up to 255.
	localparam int ROW_W = 10;
	localparam int N_W   = ROW_W - 3;

	// Function codes of a command item.
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_WINDOW_LEFT      = 3'd0;
	localparam logic [2:0] CFG_WINDOW_TOP       = 3'd1;
	localparam logic [2:0] CFG_WINDOW_WIDTH     = 3'd2;
	localparam logic [2:0] CFG_WINDOW_HEIGHT    = 3'd3;
	localparam logic [2:0] CFG_XOR_MODE         = 3'd4;
	localparam logic [2:0] CFG_PEN_WHITE        = 3'd5;
	localparam logic [2:0] CFG_BACKGROUND_WHITE = 3'd6;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_READ,
		ST_MERGE
	} st_t;

endpackage

// ===== src/wpfb_cmd_if.sv =====
// Command channel interface: valid/ready handshake with the command item.
// Depends on nothing.
interface wpfb_cmd_if;
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic signed [8:0] pos_x;
	logic signed [8:0] pos_y;
	logic [7:0]        pixel_byte;

	modport source (output valid, func, pos_x, pos_y, pixel_byte, input ready);
	modport sink   (input valid, func, pos_x, pos_y, pixel_byte, output ready);
endinterface

// ===== src/wpfb_res_if.sv =====
// Result channel interface: valid/ready handshake with the reported byte.
// Depends on nothing.
interface wpfb_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] page;
	logic [6:0] column;
	logic [7:0] data;
	logic       last;

	modport source (output valid, page, column, data, last, input ready);
	modport sink   (input valid, page, column, data, last, output ready);
endinterface

// ===== src/windowed_page_framebuffer_write.sv =====
// Top level of the windowed page frame buffer write block.
// Depends on wpfb_pkg, wpfb_cmd_if, wpfb_res_if and wpfb_ram.
//
// Usage:
//   cmd carries command items (write byte, clear, read byte); result carries
//   the reported bytes with page, column and a last flag on the final one.
//   The cfg_we / cfg_index / cfg_data port writes the window and pen
//   registers; write them only while no item is in flight.
//   One item is worked on at a time; cmd.ready is high only when idle.
//   A write goes through a prepare step, then a read and a merge step for each
//   of its one or two store bytes through the single merge unit; its first
//   result is registered in the merge step. A read item takes a read and a
//   merge step. A clear item walks all STORE_DEPTH (1024) store entries one
//   byte a cycle and gives no result. After reset the same walk fills the
//   store with zero; no command item is taken during it, but configuration
//   writes still are.
//   Results sit in an output register; while the receiver stalls, the block
//   holds in its merge cycle and takes no new item until the slot frees.
module windowed_page_framebuffer_write (
	input  logic       clk,
	input  logic       arst_n,
	wpfb_cmd_if.sink   cmd,
	wpfb_res_if.source result,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	// Configuration registers.
	logic [7:0] window_left_q;
	logic [6:0] window_top_q;
	logic [7:0] window_width_q;
	logic [6:0] window_height_q;
	logic       xor_mode_q;
	logic       pen_white_q;
	logic       background_white_q;

	// Sequencer and item registers.
	wpfb_pkg::st_t              state_q, state_d;
	logic [wpfb_pkg::ADDR_W-1:0] clr_q;
	logic [7:0]                 fill_q;
	logic signed [8:0]          x_q, y_q;
	logic [7:0]                 pixel_q;
	logic [wpfb_pkg::ADDR_W-1:0] addr_q;
	logic [wpfb_pkg::N_W-1:0]   page_q;
	logic [6:0]                 col_q;
	logic [15:0]                wide_q;
	logic                       part_q;
	logic                       do1_q;
	logic                       is_read_q;
	logic                       rd_ok_q;

	// Output register.
	logic       out_valid_q;
	logic [2:0] out_page_q;
	logic [6:0] out_col_q;
	logic [7:0] out_data_q;
	logic       out_last_q;

	// Control outputs of the sequencer.
	logic                        cmd_ready;
	logic                        out_load;
	logic                        ram_we;
	logic [wpfb_pkg::ADDR_W-1:0] ram_waddr;
	logic [7:0]                  ram_wdata;
	logic [7:0]                  ram_rdata;
	logic                        out_free;
	logic                        cmd_take;

	assign out_free = !out_valid_q || result.ready;
	assign cmd_take = cmd.valid && cmd_ready;

	// Frame store.
	wpfb_ram #(
		.WIDTH(8),
		.DEPTH(wpfb_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	// Write preparation: clip, bottom mask, negative row shift, page split.
	logic signed [10:0]         xs, ys, ws, hs, hdiff, nys;
	logic                       reject, mask_on, y_neg;
	logic [7:0]                 hi_bits, val_m, val_s;
	logic [wpfb_pkg::ROW_W-1:0] row;
	logic [2:0]                 m;
	logic [wpfb_pkg::N_W-1:0]   n, n_p1, start_n;
	logic [15:0]                wide;
	logic [9:0]                 col;
	logic                       col_ok, ok0, ok1, any_part;
	logic [wpfb_pkg::ADDR_W-1:0] start_addr;

	always_comb begin
		xs      = {{2{x_q[8]}}, x_q};
		ys      = {{2{y_q[8]}}, y_q};
		ws      = {3'b000, window_width_q};
		hs      = {4'b0000, window_height_q};
		reject  = (xs > ws) || (ys > hs) || xs[10] || (ys < -11'sd6);
		mask_on = (ys + 11'sd8) > hs;
		hdiff   = hs - ys;
		hi_bits = 8'hFF << hdiff[2:0];
		val_m   = mask_on ? (pixel_q & ~hi_bits) : pixel_q;
		y_neg   = ys[10];
		nys     = -ys;
		val_s   = y_neg ? (val_m >> nys[2:0]) : val_m;
		row     = y_neg ? {3'b000, window_top_q}
		                : ({3'b000, window_top_q} + ys[9:0]);
		m       = row[2:0];
		n       = row[wpfb_pkg::ROW_W-1:3];
		n_p1    = n + 1'b1;
		wide    = {8'h00, val_s} << m;
		col     = {2'b00, window_left_q} + {1'b0, xs[8:0]};
		col_ok  = col < 10'(wpfb_pkg::SCREEN_WIDTH);
		ok0     = n < wpfb_pkg::N_W'(wpfb_pkg::PAGE_COUNT);
		ok1     = (m != 3'd0) && (n_p1 < wpfb_pkg::N_W'(wpfb_pkg::PAGE_COUNT));
		any_part = !reject && col_ok && (ok0 || ok1);
		start_n = ok0 ? n : n_p1;
		start_addr = wpfb_pkg::ADDR_W'(32'(start_n) * wpfb_pkg::SCREEN_WIDTH + 32'(col));
	end

	// Read address and range check for a read item.
	logic                        rd_ok;
	logic [wpfb_pkg::ADDR_W-1:0] rd_addr;

	always_comb begin
		rd_ok   = !cmd.pos_x[8] && ({1'b0, cmd.pos_x[7:0]} < 9'(wpfb_pkg::SCREEN_WIDTH))
		          && !cmd.pos_y[8]
		          && ({1'b0, cmd.pos_y[7:0]} < 9'(wpfb_pkg::PAGE_COUNT));
		rd_addr = wpfb_pkg::ADDR_W'(32'(cmd.pos_y[7:0]) * wpfb_pkg::SCREEN_WIDTH
		          + 32'(cmd.pos_x[7:0]));
	end

	// The shared merge unit.
	logic [7:0] part_val, merged;

	always_comb begin
		part_val = part_q ? wide_q[15:8] : wide_q[7:0];
		if (xor_mode_q) begin
			merged = ram_rdata ^ part_val;
		end else if (pen_white_q) begin
			merged = ram_rdata | part_val;
		end else begin
			merged = ram_rdata & ~part_val;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wpfb_pkg::ST_CLEAR: begin
				if (clr_q == wpfb_pkg::ADDR_W'(wpfb_pkg::STORE_DEPTH - 1)) begin
					state_d = wpfb_pkg::ST_IDLE;
				end
			end
			wpfb_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					unique case (cmd.func)
						wpfb_pkg::FUNC_WRITE: state_d = wpfb_pkg::ST_PREP;
						wpfb_pkg::FUNC_CLEAR: state_d = wpfb_pkg::ST_CLEAR;
						wpfb_pkg::FUNC_READ:  state_d = wpfb_pkg::ST_READ;
						default:              state_d = wpfb_pkg::ST_IDLE;
					endcase
				end
			end
			wpfb_pkg::ST_PREP: begin
				state_d = any_part ? wpfb_pkg::ST_READ : wpfb_pkg::ST_IDLE;
			end
			wpfb_pkg::ST_READ: begin
				state_d = wpfb_pkg::ST_MERGE;
			end
			wpfb_pkg::ST_MERGE: begin
				if (out_free) begin
					if (!is_read_q && !part_q && do1_q) begin
						state_d = wpfb_pkg::ST_READ;
					end else begin
						state_d = wpfb_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = wpfb_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		cmd_ready = 1'b0;
		out_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = merged;
		unique case (state_q)
			wpfb_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = fill_q;
			end
			wpfb_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
			end
			wpfb_pkg::ST_MERGE: begin
				out_load = out_free;
				ram_we   = out_free && !is_read_q;
			end
			default: begin
			end
		endcase
	end

	assign cmd.ready = cmd_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_left_q      <= 8'd0;
			window_top_q       <= 7'd0;
			window_width_q     <= 8'd128;
			window_height_q    <= 7'd64;
			xor_mode_q         <= 1'b0;
			pen_white_q        <= 1'b1;
			background_white_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wpfb_pkg::CFG_WINDOW_LEFT:      window_left_q      <= cfg_data;
				wpfb_pkg::CFG_WINDOW_TOP:       window_top_q       <= cfg_data[6:0];
				wpfb_pkg::CFG_WINDOW_WIDTH:     window_width_q     <= cfg_data;
				wpfb_pkg::CFG_WINDOW_HEIGHT:    window_height_q    <= cfg_data[6:0];
				wpfb_pkg::CFG_XOR_MODE:         xor_mode_q         <= cfg_data[0];
				wpfb_pkg::CFG_PEN_WHITE:        pen_white_q        <= cfg_data[0];
				wpfb_pkg::CFG_BACKGROUND_WHITE: background_white_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Control state: the store is swept with zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wpfb_pkg::ST_CLEAR;
			clr_q       <= '0;
			fill_q      <= 8'h00;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == wpfb_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd_take && cmd.func == wpfb_pkg::FUNC_CLEAR) begin
				clr_q  <= '0;
				fill_q <= {8{background_white_q}};
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item datapath registers.
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			x_q       <= cmd.pos_x;
			y_q       <= cmd.pos_y;
			pixel_q   <= cmd.pixel_byte;
			is_read_q <= (cmd.func == wpfb_pkg::FUNC_READ);
			rd_ok_q   <= rd_ok;
			addr_q    <= rd_addr;
			page_q    <= cmd.pos_y[wpfb_pkg::N_W-1:0];
			col_q     <= cmd.pos_x[6:0];
			part_q    <= 1'b0;
			do1_q     <= 1'b0;
		end
		if (state_q == wpfb_pkg::ST_PREP) begin
			addr_q <= start_addr;
			page_q <= start_n;
			col_q  <= col[6:0];
			wide_q <= wide;
			part_q <= !ok0;
			do1_q  <= ok0 && ok1;
		end
		// Step to the lower page for the second part.
		if (out_load && !is_read_q && !part_q && do1_q) begin
			addr_q <= addr_q + wpfb_pkg::ADDR_W'(wpfb_pkg::SCREEN_WIDTH);
			page_q <= page_q + 1'b1;
			part_q <= 1'b1;
		end
		if (out_load) begin
			out_page_q <= page_q[2:0];
			out_col_q  <= col_q;
			out_data_q <= is_read_q ? (rd_ok_q ? ram_rdata : 8'h00) : merged;
			out_last_q <= is_read_q || part_q || !do1_q;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.page   = out_page_q;
	assign result.column = out_col_q;
	assign result.data   = out_data_q;
	assign result.last   = out_last_q;

	// A read item goes straight to the store read cycle.
	a_read_goes_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && cmd.func == wpfb_pkg::FUNC_READ) |=> state_q == wpfb_pkg::ST_READ)
		else $error("read item did not start a store read");

	// A merge cycle with a free slot always presents a result next cycle.
	a_merge_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wpfb_pkg::ST_MERGE && out_free) |=> out_valid_q)
		else $error("merge cycle did not present a result");

	// The fill sweep ends after its final entry.
	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wpfb_pkg::ST_CLEAR
		 && clr_q == wpfb_pkg::ADDR_W'(wpfb_pkg::STORE_DEPTH - 1))
		|=> state_q == wpfb_pkg::ST_IDLE)
		else $error("fill sweep did not finish");

	// Only a write item has a second part.
	a_second_part_is_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wpfb_pkg::ST_MERGE && part_q) |-> !is_read_q)
		else $error("read item reached a second part");

endmodule

// ===== src/wpfb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module wpfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents when the same entry is written.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== verif/tb_windowed_page_framebuffer_write.sv =====
// Self-checking testbench for the windowed page frame buffer write block.
// Depends on wpfb_pkg, wpfb_cmd_if, wpfb_res_if and the block's top level.
// A shadow frame store predicts every reported byte; results are checked in order.
module tb_windowed_page_framebuffer_write;
	import wpfb_pkg::*;

	// Function code that the block accepts and ignores.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam int DRAIN_PAUSE      = STORE_DEPTH + 80;
	localparam int END_PAUSE        = 24;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int LONG_HOLD_STEP   = 350;
	localparam int PHASE_ITEMS      = 114;

	typedef struct {
		logic [1:0]        func;
		logic signed [8:0] pos_x;
		logic signed [8:0] pos_y;
		logic [7:0]        pixel_byte;
	} pixel_cmd_t;

	typedef struct {
		logic [2:0] page;
		logic [6:0] column;
		logic [7:0] data;
		logic       last;
	} page_byte_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	wpfb_cmd_if cmd_ch ();
	wpfb_res_if res_ch ();

	windowed_page_framebuffer_write u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the frame store and the window and pen registers.
	logic [7:0] frame_model [STORE_DEPTH];
	logic [7:0] win_left;
	logic [6:0] win_top;
	logic [7:0] win_width;
	logic [6:0] win_height;
	logic       pen_xor;
	logic       pen_white;
	logic       bg_white;

	pixel_cmd_t pending_cmds [$];
	page_byte_t expected_bytes [$];
	pixel_cmd_t cur_cmd;

	int  fail_count;
	int  results_seen;
	int  quiet_cycles;
	int  send_gap;
	int  long_holds;
	int  recent_col;
	int  recent_page;
	bit  sender_gappy;
	bit  receiver_gappy;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle length after an item or a ready cycle: mostly none, a few long ones.
	function automatic int pick_gap(bit gappy);
		int r;
		if (!gappy)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Merge one byte into the shadow store; returns 0 when it lies off the screen.
	function automatic bit merge_part(int col, int pg, logic [7:0] val,
			output page_byte_t res);
		int idx;
		logic [7:0] b;
		res = '{default: '0};
		if (col < 0 || col > SCREEN_WIDTH - 1 || pg < 0 || pg > PAGE_COUNT - 1)
			return 1'b0;
		idx = pg * SCREEN_WIDTH + col;
		b = frame_model[idx];
		if (pen_xor)
			b = b ^ val;
		else if (pen_white)
			b = b | val;
		else
			b = b & ~val;
		frame_model[idx] = b;
		res.page = pg[2:0];
		res.column = col[6:0];
		res.data = b;
		return 1'b1;
	endfunction

	// Work out the bytes that one accepted item reports and update the shadow store.
	function automatic void apply_command(pixel_cmd_t c);
		int x, y, w, h, row, pg, off, col;
		logic [7:0] val;
		logic [15:0] wide;
		page_byte_t r0, r1;
		bit ok0, ok1;
		x = c.pos_x;
		y = c.pos_y;
		case (c.func)
			FUNC_WRITE: begin
				w = int'(win_width);
				h = int'(win_height);
				val = c.pixel_byte;
				if (x > w || y > h || x < 0 || y <= -7)
					return;
				// Bits that fall below the window bottom are dropped.
				if (y + 7 > h - 1)
					val = val & 8'((1 << (h - y)) - 1);
				if (y < 0) begin
					val = val >> (-y);
					row = int'(win_top);
				end else begin
					row = int'(win_top) + y;
				end
				pg = row / 8;
				off = row % 8;
				col = int'(win_left) + x;
				wide = {8'h00, val} << off;
				ok0 = merge_part(col, pg, wide[7:0], r0);
				ok1 = 1'b0;
				if (off != 0)
					ok1 = merge_part(col, pg + 1, wide[15:8], r1);
				if (ok0) begin
					r0.last = !ok1;
					expected_bytes.push_back(r0);
				end
				if (ok1) begin
					r1.last = 1'b1;
					expected_bytes.push_back(r1);
				end
			end
			FUNC_CLEAR: begin
				foreach (frame_model[i])
					frame_model[i] = bg_white ? 8'hFF : 8'h00;
			end
			FUNC_READ: begin
				r0.data = 8'h00;
				if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < PAGE_COUNT)
					r0.data = frame_model[y * SCREEN_WIDTH + x];
				r0.page = c.pos_y[2:0];
				r0.column = c.pos_x[6:0];
				r0.last = 1'b1;
				expected_bytes.push_back(r0);
			end
			default: ;
		endcase
	endfunction

	// Command driver: presents queued items and predicts each one on acceptance.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				apply_command(cur_cmd);
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_ch.valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cur_cmd = pending_cmds.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.func <= cur_cmd.func;
					cmd_ch.pos_x <= cur_cmd.pos_x;
					cmd_ch.pos_y <= cur_cmd.pos_y;
					cmd_ch.pixel_byte <= cur_cmd.pixel_byte;
					send_gap = pick_gap(sender_gappy);
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each accepted byte against the oldest expectation
	// and drives ready, with random stalls and a few long hold-offs.
	always @(posedge clk) begin : result_monitor
		page_byte_t want;
		int gap;
		int hold_left;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected result: page %0d column %0d data %02h last %0b",
						$time, res_ch.page, res_ch.column, res_ch.data, res_ch.last);
					fail_count++;
				end else begin
					want = expected_bytes.pop_front();
					if (res_ch.page !== want.page || res_ch.column !== want.column ||
							res_ch.data !== want.data || res_ch.last !== want.last) begin
						$display("%0t: mismatch: expected page %0d column %0d data %02h last %0b",
							$time, want.page, want.column, want.data, want.last);
						$display("%0t:           got page %0d column %0d data %02h last %0b",
							$time, res_ch.page, res_ch.column, res_ch.data, res_ch.last);
						fail_count++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (long_holds < 2 && results_seen >= LONG_HOLD_STEP * (long_holds + 1))
					begin
				// Long hold-off so that the block backs up and stalls its input.
				long_holds++;
				hold_left = LONG_HOLD_CYCLES - 1;
				res_ch.ready <= 1'b0;
			end else begin
				gap = pick_gap(receiver_gappy);
				if (gap > 0) begin
					hold_left = gap - 1;
					res_ch.ready <= 1'b0;
				end else begin
					res_ch.ready <= 1'b1;
				end
			end
		end
	end

	// Watchdog: counts cycles with no handshake and no register write.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic write_register(logic [2:0] idx, logic [7:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_WINDOW_LEFT:      win_left = value;
			CFG_WINDOW_TOP:       win_top = value[6:0];
			CFG_WINDOW_WIDTH:     win_width = value;
			CFG_WINDOW_HEIGHT:    win_height = value[6:0];
			CFG_XOR_MODE:         pen_xor = value[0];
			CFG_PEN_WHITE:        pen_white = value[0];
			CFG_BACKGROUND_WHITE: bg_white = value[0];
			default: ;
		endcase
	endtask

	task automatic write_window(logic [7:0] left, logic [7:0] top, logic [7:0] width,
			logic [7:0] height, logic [7:0] xm, logic [7:0] pw, logic [7:0] bg);
		write_register(CFG_WINDOW_LEFT, left);
		write_register(CFG_WINDOW_TOP, top);
		write_register(CFG_WINDOW_WIDTH, width);
		write_register(CFG_WINDOW_HEIGHT, height);
		write_register(CFG_XOR_MODE, xm);
		write_register(CFG_PEN_WHITE, pw);
		write_register(CFG_BACKGROUND_WHITE, bg);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Window and pen settings drawn at random, sometimes with the unused high bits set.
	task automatic random_window();
		logic [7:0] left, top, width, height;
		left   = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 120)) : 8'($urandom);
		top    = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 63)) : 8'($urandom);
		width  = ($urandom_range(0, 99) < 50) ? 8'($urandom_range(0, 127)) : 8'($urandom);
		height = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 64)) : 8'($urandom);
		write_window(left, top, width, height,
			{7'($urandom), 1'($urandom_range(0, 99) < 30)},
			{7'($urandom), 1'($urandom)},
			{7'($urandom), 1'($urandom)});
	endtask

	function automatic void queue_cmd(logic [1:0] f, int x, int y, logic [7:0] b);
		pixel_cmd_t c;
		c.func = f;
		c.pos_x = 9'(x);
		c.pos_y = 9'(y);
		c.pixel_byte = b;
		pending_cmds.push_back(c);
	endfunction

	// One random item: mostly writes near the window, reads aimed at recent writes,
	// now and then a clear, an unused code or fully random coordinates.
	function automatic void queue_random_cmd();
		int r, x, y, w, h;
		logic [7:0] b;
		w = int'(win_width);
		h = int'(win_height);
		r = $urandom_range(0, 99);
		b = ($urandom_range(0, 9) == 0) ? {8{1'($urandom)}} : 8'($urandom);
		if (r < 4) begin
			queue_cmd(FUNC_CLEAR, int'($urandom), int'($urandom), b);
		end else if (r < 6) begin
			queue_cmd(FUNC_UNUSED, int'($urandom), int'($urandom), b);
		end else if (r < 28) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				x = recent_col;
				y = recent_page + $urandom_range(0, 1);
			end else if (r < 85) begin
				x = $urandom_range(0, SCREEN_WIDTH - 1);
				y = $urandom_range(0, PAGE_COUNT - 1);
			end else begin
				x = int'($urandom);
				y = int'($urandom);
			end
			queue_cmd(FUNC_READ, x, y, b);
		end else begin
			if ($urandom_range(0, 99) < 80)
				x = $urandom_range(0, (w + 1 > 255) ? 255 : w + 1);
			else
				x = int'(9'($urandom));
			if ($urandom_range(0, 99) < 80)
				y = int'($urandom_range(0, h + 8)) - 7;
			else
				y = int'($signed(9'($urandom)));
			recent_col = (int'(win_left) + (x & 255)) % SCREEN_WIDTH;
			recent_page = ((int'(win_top) + ((y < 0) ? 0 : (y & 255))) / 8) % PAGE_COUNT;
			queue_cmd(FUNC_WRITE, x, y, b);
		end
	endfunction

	// Wait until every item is taken and every result has come, then let the
	// block finish any clear walk still in progress.
	task automatic wait_drained(int pause);
		while (pending_cmds.size() != 0 || cmd_ch.valid || expected_bytes.size() != 0)
			@(negedge clk);
		repeat (pause) @(posedge clk);
	endtask

	task automatic run_phase(int count, bit s_gappy, bit r_gappy);
		@(negedge clk);
		sender_gappy = s_gappy;
		receiver_gappy = r_gappy;
		repeat (count) queue_random_cmd();
		wait_drained(DRAIN_PAUSE);
	endtask

	// Stimulus: reset, directed items at the reset settings, then random phases.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WINDOW_LEFT;
		cfg_data = 8'h00;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = FUNC_WRITE;
		cmd_ch.pos_x = '0;
		cmd_ch.pos_y = '0;
		cmd_ch.pixel_byte = 8'h00;
		res_ch.ready = 1'b0;
		foreach (frame_model[i])
			frame_model[i] = 8'h00;
		win_left = 8'd0;
		win_top = 7'd0;
		win_width = 8'd128;
		win_height = 7'd64;
		pen_xor = 1'b0;
		pen_white = 1'b1;
		bg_white = 1'b0;
		fail_count = 0;
		results_seen = 0;
		send_gap = 0;
		long_holds = 0;
		recent_col = 0;
		recent_page = 0;
		sender_gappy = 1'b0;
		receiver_gappy = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items: clipping edges, shifts, page splits and read ranges.
		@(negedge clk);
		queue_cmd(FUNC_WRITE, 0, 0, 8'hFF);
		queue_cmd(FUNC_WRITE, 5, 3, 8'hA5);
		queue_cmd(FUNC_WRITE, 127, 63, 8'hFF);
		queue_cmd(FUNC_WRITE, 128, 0, 8'hFF);
		queue_cmd(FUNC_WRITE, 129, 0, 8'hFF);
		queue_cmd(FUNC_WRITE, -1, 0, 8'hFF);
		queue_cmd(FUNC_WRITE, 10, -6, 8'hFF);
		queue_cmd(FUNC_WRITE, 11, -1, 8'h80);
		queue_cmd(FUNC_WRITE, 12, -7, 8'hFF);
		queue_cmd(FUNC_WRITE, 13, 64, 8'hFF);
		queue_cmd(FUNC_WRITE, 14, 65, 8'hFF);
		queue_cmd(FUNC_WRITE, 255, 255, 8'hFF);
		queue_cmd(FUNC_WRITE, -256, -256, 8'h00);
		queue_cmd(FUNC_WRITE, 20, 8, 8'h00);
		queue_cmd(FUNC_WRITE, 21, 56, 8'h5A);
		queue_cmd(FUNC_READ, 0, 0, 8'h00);
		queue_cmd(FUNC_READ, 5, 0, 8'h00);
		queue_cmd(FUNC_READ, 127, 7, 8'h00);
		queue_cmd(FUNC_READ, 128, 0, 8'h00);
		queue_cmd(FUNC_READ, -1, -1, 8'h00);
		queue_cmd(FUNC_READ, 255, 255, 8'h00);
		queue_cmd(FUNC_READ, -256, -256, 8'h00);
		queue_cmd(FUNC_UNUSED, -1, -1, 8'hFF);
		queue_cmd(FUNC_CLEAR, 0, 0, 8'h00);
		queue_cmd(FUNC_READ, 5, 1, 8'h00);
		wait_drained(DRAIN_PAUSE);

		// Smallest window, white background.
		write_window(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01);
		run_phase(80, 1'b1, 1'b1);

		// Largest window values, all high bits set; writes land off the screen.
		write_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'h00);
		run_phase(80, 1'b0, 1'b0);

		for (int p = 0; p < 10; p++) begin
			random_window();
			run_phase(PHASE_ITEMS, p[0], p[1] | p[2]);
		end

		// Back to the reset settings with XOR merge.
		write_window(8'h00, 8'h00, 8'h80, 8'h40, 8'h01, 8'h01, 8'h00);
		run_phase(PHASE_ITEMS, 1'b1, 1'b0);

		wait_drained(END_PAUSE);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
